// ----- hw/rtl/pbdc_pkg.sv -----
// Shared constants, codes and types for the pushbutton debounce and chord event block.
package pbdc_pkg;

  localparam int unsigned PortWidthDef = 8;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned CountW       = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CodeW        = 4;
  localparam int unsigned NumSlots     = 6;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_WATCH_MASK      = 3'd0,
    REG_DEBOUNCE_TICKS  = 3'd1,
    REG_SET_MASK        = 3'd2,
    REG_START_STOP_MASK = 3'd3,
    REG_MODE_MASK       = 3'd4
  } cfg_reg_e;

  localparam logic [7:0]        WatchMaskRst     = 8'd7;
  localparam logic [CountW-1:0] DebounceTicksRst = 16'd50;
  localparam logic [7:0]        SetMaskRst       = 8'd1;
  localparam logic [7:0]        StartStopMaskRst = 8'd2;
  localparam logic [7:0]        ModeMaskRst      = 8'd4;

  // event codes
  localparam logic [CodeW-1:0] EV_ALL_REL  = 4'd0;
  localparam logic [CodeW-1:0] EV_MS_REL   = 4'd1;
  localparam logic [CodeW-1:0] EV_SET_REL  = 4'd2;
  localparam logic [CodeW-1:0] EV_SS_REL   = 4'd3;
  localparam logic [CodeW-1:0] EV_MODE_REL = 4'd4;
  localparam logic [CodeW-1:0] EV_ALL_PRS  = 4'd5;
  localparam logic [CodeW-1:0] EV_MS_PRS   = 4'd6;
  localparam logic [CodeW-1:0] EV_SET_PRS  = 4'd7;
  localparam logic [CodeW-1:0] EV_SS_PRS   = 4'd8;
  localparam logic [CodeW-1:0] EV_MODE_PRS = 4'd9;

  // Fixed event slots: [0] set/chord rel, [1] ss rel, [2] mode rel, [3..5] same pressed
  typedef struct packed {
    logic [NumSlots-1:0] valid;
    logic [CodeW-1:0]    rel_code;
    logic [CodeW-1:0]    prs_code;
  } ev_slots_t;

endpackage

// ----- hw/rtl/pbdc_eval.sv -----
// Button classification and event slot generation for one sampled port value.
module pbdc_eval #(
  parameter int unsigned PORT_WIDTH = pbdc_pkg::PortWidthDef
) (
  input  logic [PORT_WIDTH-1:0] port_i,
  input  logic [PORT_WIDTH-1:0] stable_i,
  input  logic [PORT_WIDTH-1:0] set_mask_i,
  input  logic [PORT_WIDTH-1:0] start_stop_mask_i,
  input  logic [PORT_WIDTH-1:0] mode_mask_i,
  output pbdc_pkg::ev_slots_t   slots_o
);
  import pbdc_pkg::*;

  // {released, pressed} for one button
  function automatic logic [1:0] classify(input logic [PORT_WIDTH-1:0] m,
                                          input logic [PORT_WIDTH-1:0] port,
                                          input logic [PORT_WIDTH-1:0] stable);
    logic [PORT_WIDTH-1:0] now;
    logic                  changed;
    now     = port & m;
    changed = (stable & m) != now;
    return {changed && (now == '0), changed && (now != '0) && (now == m)};
  endfunction

  logic [1:0]            c_set, c_ss, c_mode;
  logic [PORT_WIDTH-1:0] rel_bits, prs_bits;
  logic                  r_s, r_ss, r_m, p_s, p_ss, p_m;
  logic                  r_all, r_comb, p_all, p_comb;

  always_comb begin
    c_set  = classify(set_mask_i, port_i, stable_i);
    c_ss   = classify(start_stop_mask_i, port_i, stable_i);
    c_mode = classify(mode_mask_i, port_i, stable_i);

    rel_bits = (c_set[1] ? set_mask_i : '0) | (c_ss[1] ? start_stop_mask_i : '0) |
               (c_mode[1] ? mode_mask_i : '0);
    prs_bits = (c_set[0] ? set_mask_i : '0) | (c_ss[0] ? start_stop_mask_i : '0) |
               (c_mode[0] ? mode_mask_i : '0);

    // overlapping masks may flag a neighbour too
    r_s  = |(rel_bits & set_mask_i);
    r_ss = |(rel_bits & start_stop_mask_i);
    r_m  = |(rel_bits & mode_mask_i);
    p_s  = |(prs_bits & set_mask_i);
    p_ss = |(prs_bits & start_stop_mask_i);
    p_m  = |(prs_bits & mode_mask_i);

    r_all  = r_s & r_ss & r_m;
    r_comb = !r_s & r_ss & r_m;
    p_all  = p_s & p_ss & p_m;
    p_comb = !p_s & p_ss & p_m;

    slots_o.valid = {p_m && !(p_all || p_comb), p_ss && !(p_all || p_comb), p_s || p_comb,
                     r_m && !(r_all || r_comb), r_ss && !(r_all || r_comb), r_s || r_comb};
    slots_o.rel_code = r_all ? EV_ALL_REL : (r_comb ? EV_MS_REL : EV_SET_REL);
    slots_o.prs_code = p_all ? EV_ALL_PRS : (p_comb ? EV_MS_PRS : EV_SET_PRS);
  end

endmodule

// ----- hw/rtl/pushbutton_debounce_chord_events.sv -----
// Top level: pushbutton debounce with edge and chord events.
// The first event of a tick is shown in the cycle after the tick's beat is taken.
// A tick that emits nothing leaves the block ready for the next; a tick with events keeps
//   the output busy until all have left; the next tick is taken as its last event leaves.
// The six-slot event register is the limit: one event beat per cycle, less when stalled.
// Reset: registers to their defaults, stable value, primed, waiting and count to zero.
module pushbutton_debounce_chord_events #(
  parameter int unsigned PORT_WIDTH = pbdc_pkg::PortWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pbdc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pbdc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [PORT_WIDTH-1:0]              port_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pbdc_pkg::CodeW-1:0]         event_code_o,
  output logic                               last_event_o
);
  import pbdc_pkg::*;

  logic [PORT_WIDTH-1:0] watch_mask_q, set_mask_q, ss_mask_q, mode_mask_q;
  logic [CountW-1:0]     debounce_ticks_q;
  logic [PORT_WIDTH-1:0] stable_q, stable_d;
  logic                  primed_q, primed_d, waiting_q, waiting_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [NumSlots-1:0]   pend_q, pend_d;
  logic [CodeW-1:0]      rel_code_q, prs_code_q;
  logic                  in_fire, out_fire, sample_now, single;
  ev_slots_t             slots;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_mask_q     <= PORT_WIDTH'(WatchMaskRst);
      debounce_ticks_q <= DebounceTicksRst;
      set_mask_q       <= PORT_WIDTH'(SetMaskRst);
      ss_mask_q        <= PORT_WIDTH'(StartStopMaskRst);
      mode_mask_q      <= PORT_WIDTH'(ModeMaskRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WATCH_MASK:      watch_mask_q     <= PORT_WIDTH'(cfg_wdata_i[7:0]);
        REG_DEBOUNCE_TICKS:  debounce_ticks_q <= cfg_wdata_i[CountW-1:0];
        REG_SET_MASK:        set_mask_q       <= PORT_WIDTH'(cfg_wdata_i[7:0]);
        REG_START_STOP_MASK: ss_mask_q        <= PORT_WIDTH'(cfg_wdata_i[7:0]);
        REG_MODE_MASK:       mode_mask_q      <= PORT_WIDTH'(cfg_wdata_i[7:0]);
        default: ;
      endcase
    end
  end

  pbdc_eval #(
    .PORT_WIDTH(PORT_WIDTH)
  ) u_eval (
    .port_i           (port_sample_i),
    .stable_i         (stable_q),
    .set_mask_i       (set_mask_q),
    .start_stop_mask_i(ss_mask_q),
    .mode_mask_i      (mode_mask_q),
    .slots_o          (slots)
  );

  // one pending event left means its beat frees the slot register
  assign single     = (pend_q != '0) && ((pend_q & (pend_q - 1'b1)) == '0);
  assign out_valid_o = pend_q != '0;
  assign out_fire   = out_valid_o && out_ready_i;
  assign in_ready_o = (pend_q == '0) || (single && out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign sample_now = primed_q && waiting_q && (count_q == '0);
  assign last_event_o = single;

  always_comb begin
    stable_d  = stable_q;
    primed_d  = primed_q;
    waiting_d = waiting_q;
    count_d   = count_q;
    pend_d    = pend_q;
    if (out_fire) begin
      pend_d = pend_q & (pend_q - 1'b1);
    end
    if (in_fire) begin
      if (!primed_q) begin
        stable_d = port_sample_i;
        primed_d = 1'b1;
      end else if (!waiting_q) begin
        if (((port_sample_i ^ stable_q) & watch_mask_q) != '0) begin
          waiting_d = 1'b1;
          count_d   = debounce_ticks_q;
        end
      end else if (count_q != '0) begin
        count_d = count_q - 1'b1;
      end else begin
        stable_d  = port_sample_i;
        waiting_d = 1'b0;
      end
      pend_d = sample_now ? slots.valid : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= '0;
      primed_q  <= 1'b0;
      waiting_q <= 1'b0;
      count_q   <= '0;
      pend_q    <= '0;
    end else begin
      stable_q  <= stable_d;
      primed_q  <= primed_d;
      waiting_q <= waiting_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && sample_now) begin
      rel_code_q <= slots.rel_code;
      prs_code_q <= slots.prs_code;
    end
  end

  // lowest pending slot goes out first
  always_comb begin
    if (pend_q[0]) begin
      event_code_o = rel_code_q;
    end else if (pend_q[1]) begin
      event_code_o = EV_SS_REL;
    end else if (pend_q[2]) begin
      event_code_o = EV_MODE_REL;
    end else if (pend_q[3]) begin
      event_code_o = prs_code_q;
    end else if (pend_q[4]) begin
      event_code_o = EV_SS_PRS;
    end else begin
      event_code_o = EV_MODE_PRS;
    end
  end

endmodule

// ----- hw/rtl/pbdc_checker.sv -----
// Port-level checks for the pushbutton debounce and chord event block, bound to the top level.
module pbdc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [pbdc_pkg::CodeW-1:0]   event_code_o,
  input logic                         last_event_o
);
  import pbdc_pkg::*;

  // a new tick only enters when the last event of the previous run leaves
  a_in_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_valid_o) |-> (out_ready_i && last_event_o))
    else $error("tick taken while events of the previous tick remain");

  // a run does not break off before its last event
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_event_o) |=> out_valid_o)
    else $error("event run ended without a last event");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o <= EV_MODE_PRS))
    else $error("event code out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(event_code_o) && $stable(last_event_o)))
    else $error("stalled event beat changed");

endmodule

bind pushbutton_debounce_chord_events pbdc_checker u_pbdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .event_code_o(event_code_o),
  .last_event_o(last_event_o)
);

// ----- tb/sv/pushbutton_debounce_chord_events_checker.sv -----
`timescale 1ns / 100ps
// Checker for the chord event block: tracks debounce state, predicts events, compares beats.
module pushbutton_debounce_chord_events_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pbdc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pbdc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [pbdc_pkg::PortWidthDef-1:0]  port_sample_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [pbdc_pkg::CodeW-1:0]         event_code_i,
  input  logic                               last_event_i,
  output int                                 fail_count_o,
  output int                                 events_owed_o,
  output int                                 events_checked_o,
  output logic                               primed_o,
  output logic                               waiting_o,
  output logic [pbdc_pkg::CountW-1:0]        wait_left_o,
  output logic [pbdc_pkg::PortWidthDef-1:0]  settled_port_o
);
  import pbdc_pkg::*;

  typedef logic [PortWidthDef-1:0] port_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             is_last;
  } chord_event_t;

  // register copies
  port_t             watch_bits;
  logic [CountW-1:0] hold_ticks;
  port_t             set_bits;
  port_t             ss_bits;
  port_t             mode_bits;

  // debounce state
  port_t             settled_port;
  logic              primed;
  logic              waiting;
  logic [CountW-1:0] wait_left;

  chord_event_t      owed_events[$];
  logic [CodeW-1:0]  tick_codes[$];
  chord_event_t      head;
  int                fail_count;
  int                events_checked;

  // classify one button against the settled value; ignored when only partly moved
  task automatic sort_button(input port_t mask, input port_t sample,
                             inout port_t released, inout port_t pressed);
    port_t now_bits;
    now_bits = sample & mask;
    if ((settled_port & mask) != now_bits) begin
      if (now_bits == '0) released |= mask;
      else if (now_bits == mask) pressed |= mask;
    end
  endtask

  task automatic list_group(input port_t flags, input bit is_press);
    bit f_set, f_ss, f_mode;
    f_set  = |(flags & set_bits);
    f_ss   = |(flags & ss_bits);
    f_mode = |(flags & mode_bits);
    if (f_set && f_ss && f_mode) begin
      tick_codes.push_back(is_press ? EV_ALL_PRS : EV_ALL_REL);
    end else if (!f_set && f_ss && f_mode) begin
      tick_codes.push_back(is_press ? EV_MS_PRS : EV_MS_REL);
    end else begin
      if (f_set) tick_codes.push_back(is_press ? EV_SET_PRS : EV_SET_REL);
      if (f_ss) tick_codes.push_back(is_press ? EV_SS_PRS : EV_SS_REL);
      if (f_mode) tick_codes.push_back(is_press ? EV_MODE_PRS : EV_MODE_REL);
    end
  endtask

  task automatic take_tick(input port_t port);
    port_t released, pressed;
    released = '0;
    pressed  = '0;
    if (!primed) begin
      settled_port = port;
      primed = 1'b1;
    end else if (!waiting) begin
      if (((port ^ settled_port) & watch_bits) != '0) begin
        waiting   = 1'b1;
        wait_left = hold_ticks;
      end
    end else if (wait_left != '0) begin
      wait_left = wait_left - 1'b1;
    end else begin
      sort_button(set_bits, port, released, pressed);
      sort_button(ss_bits, port, released, pressed);
      sort_button(mode_bits, port, released, pressed);
      tick_codes.delete();
      list_group(released, 1'b0);
      list_group(pressed, 1'b1);
      foreach (tick_codes[k]) begin
        owed_events.push_back('{code: tick_codes[k], is_last: (k == tick_codes.size() - 1)});
      end
      settled_port = port;
      waiting = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_bits     = WatchMaskRst;
      hold_ticks     = DebounceTicksRst;
      set_bits       = SetMaskRst;
      ss_bits        = StartStopMaskRst;
      mode_bits      = ModeMaskRst;
      settled_port   = '0;
      primed         = 1'b0;
      waiting        = 1'b0;
      wait_left      = '0;
      owed_events.delete();
      fail_count     = 0;
      events_checked = 0;
    end else begin
      // compare first: an event beat never belongs to a tick taken at the same edge
      if (out_valid_i && out_ready_i) begin
        events_checked++;
        if (owed_events.size() == 0) begin
          fail_count++;
          $error("event beat with nothing owed: event_code %0d last_event %0b",
                 event_code_i, last_event_i);
        end else begin
          head = owed_events.pop_front();
          if (event_code_i !== head.code) begin
            fail_count++;
            $error("event_code: expected %0d, actual %0d", head.code, event_code_i);
          end
          if (last_event_i !== head.is_last) begin
            fail_count++;
            $error("last_event: expected %0b, actual %0b", head.is_last, last_event_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WATCH_MASK:      watch_bits = cfg_wdata_i[7:0];
          REG_DEBOUNCE_TICKS:  hold_ticks = cfg_wdata_i[CountW-1:0];
          REG_SET_MASK:        set_bits   = cfg_wdata_i[7:0];
          REG_START_STOP_MASK: ss_bits    = cfg_wdata_i[7:0];
          REG_MODE_MASK:       mode_bits  = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_tick(port_sample_i);
    end
    fail_count_o     = fail_count;
    events_owed_o    = owed_events.size();
    events_checked_o = events_checked;
    primed_o         = primed;
    waiting_o        = waiting;
    wait_left_o      = wait_left;
    settled_port_o   = settled_port;
  end

endmodule

// ----- tb/sv/pushbutton_debounce_chord_events_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the chord event block: poll-tick stimulus, register phases and verdict.
module pushbutton_debounce_chord_events_test;
  import pbdc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned LongWaitTicks = 8;
  localparam logic [CfgIdxW-1:0] RegIdxUnused = 3'd7;
  localparam logic [7:0] DirectedTicks [24] = '{
    8'h00, 8'h07, 8'h07, 8'h00, 8'h00, 8'h06, 8'h06, 8'h01, 8'h01, 8'h02, 8'h02, 8'h04,
    8'h04, 8'h00, 8'h00, 8'h03, 8'h03, 8'h04, 8'h04, 8'h01, 8'h00, 8'hF8, 8'hFF, 8'hFF
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          port_sample_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CodeW-1:0]    event_code_o;
  logic                last_event_o;

  int                  fail_count;
  int                  events_owed;
  int                  events_checked;
  logic                primed;
  logic                waiting;
  logic [CountW-1:0]   wait_left;
  logic [7:0]          settled_port;

  // stimulus-side copies of the masks, for steering buttons
  logic [7:0]          watch_bits;
  logic [7:0]          set_bits;
  logic [7:0]          ss_bits;
  logic [7:0]          mode_bits;
  logic [7:0]          aimed_value;
  bit                  steady;
  int                  ticks_sent;
  int                  settings_used;
  int                  cycle_count;

  pushbutton_debounce_chord_events dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .port_sample_i(port_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .last_event_o (last_event_o)
  );

  pushbutton_debounce_chord_events_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .port_sample_i   (port_sample_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_code_i    (event_code_o),
    .last_event_i    (last_event_o),
    .fail_count_o    (fail_count),
    .events_owed_o   (events_owed),
    .events_checked_o(events_checked),
    .primed_o        (primed),
    .waiting_o       (waiting),
    .wait_left_o     (wait_left),
    .settled_port_o  (settled_port)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** pushbutton_debounce_chord_events: FAILED **");
      $finish;
    end
  end

  // event sink: random stalls except in steady stretches, held low in reset
  always @(negedge clk_i) begin
    out_ready_i = rst_ni && (steady || ($urandom_range(0, 99) >= 15));
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // drop valid and let every owed event drain, then idle for a silent tick
  task automatic settle();
    in_valid_i = 1'b0;
    while (events_owed != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] watch, input logic [15:0] ticks,
                              input logic [15:0] s, input logic [15:0] ss,
                              input logic [15:0] m);
    settle();
    write_reg(REG_WATCH_MASK, watch);
    write_reg(REG_DEBOUNCE_TICKS, ticks);
    write_reg(REG_SET_MASK, s);
    write_reg(REG_START_STOP_MASK, ss);
    write_reg(REG_MODE_MASK, m);
    watch_bits = watch[7:0];
    set_bits   = s[7:0];
    ss_bits    = ss[7:0];
    mode_bits  = m[7:0];
    settings_used++;
  endtask

  task automatic send_tick(input logic [7:0] value);
    if (!steady) begin
      while ($urandom_range(0, 99) < 15) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i    = 1'b1;
    port_sample_i = value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  function automatic logic [7:0] steer(input logic [7:0] v, input logic [7:0] mask);
    case ($urandom_range(0, 3))
      0: return v & ~mask;
      1: return v | mask;
      2: return (v & ~mask) | (8'($urandom) & mask);
      default: return v;
    endcase
  endfunction

  function automatic logic [7:0] aim_buttons();
    logic [7:0] v;
    v = steer(settled_port, set_bits);
    v = steer(v, ss_bits);
    v = steer(v, mode_bits);
    if ($urandom_range(0, 3) == 0) v ^= 8'($urandom) & ~(set_bits | ss_bits | mode_bits);
    return v;
  endfunction

  // mostly clean press/release sequences: change beat, bounce during the wait, then the target
  task automatic next_tick();
    logic [7:0] value;
    value = 8'($urandom);
    if (primed && !waiting) begin
      aimed_value = aim_buttons();
      if ($urandom_range(0, 9) != 0) value = aimed_value;
    end else if (waiting && wait_left == '0 && $urandom_range(0, 7) != 0) begin
      value = aimed_value;
    end
    send_tick(value);
  endtask

  task automatic run_phase(input int count);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) settle();
      next_tick();
    end
  endtask

  initial begin
    logic [7:0] s, ss, m;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_WATCH_MASK;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    port_sample_i = '0;
    aimed_value   = '0;
    steady        = 1'b0;
    ticks_sent    = 0;
    settings_used = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default buttons, no debounce wait; upper data bits must be dropped
    write_reg(RegIdxUnused, 16'hFFFF);
    program_regs(16'hFF07, 16'h0000, 16'h0101, 16'h8002, 16'h4004);
    foreach (DirectedTicks[i]) send_tick(DirectedTicks[i]);

    program_regs(16'h0007, 16'd2, 16'h0001, 16'h0002, 16'h0004);
    run_phase(60);

    // multi-bit buttons, so partial presses get ignored; no idling on either side
    steady = 1'b1;
    program_regs(16'h00FF, 16'd1, 16'h0003, 16'h000C, 16'h0030);
    run_phase(60);
    steady = 1'b0;

    // overlapping masks flag neighbors
    program_regs(16'h000F, 16'd0, 16'h0003, 16'h0006, 16'h000C);
    run_phase(50);

    // nothing watched, then an all-zero set mask
    program_regs(16'h0000, 16'd0, 16'h0000, 16'h00F0, 16'h000F);
    run_phase(15);
    program_regs(16'h00FF, 16'd3, 16'h0000, 16'h00F0, 16'h000F);
    run_phase(40);

    repeat (4) begin
      s  = 8'($urandom);
      ss = 8'($urandom);
      m  = 8'($urandom);
      program_regs({8'h00, ($urandom_range(0, 3) == 0) ? 8'($urandom) : (s | ss | m)},
                   16'($urandom_range(0, 3)), {8'h00, s}, {8'h00, ss}, {8'h00, m});
      run_phase(30);
    end

    // longest debounce wait with full masks; the run ends while it counts down
    program_regs(16'h00FF, 16'hFFFF, 16'h00FF, 16'h00FF, 16'h00FF);
    run_phase(LongWaitTicks);

    settle();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d poll ticks over %0d register settings, incl. zero and full masks,",
             ticks_sent, settings_used);
    $display("no and longest debounce wait; %0d event beats compared.", events_checked);
    if (fail_count == 0) begin
      $display("** pushbutton_debounce_chord_events: PASSED **");
    end else begin
      $display("** pushbutton_debounce_chord_events: FAILED **");
    end
    $finish;
  end

endmodule
